FILE: rtl/mii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mii_pkg
// Shared types and constants of the masked integral image block.
// ----------------------------------------------------------------------------
package mii_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FILL_OUTSIDE = 2'd1;
    localparam logic [1:0] CFG_COUNT_MODE   = 2'd2;

    localparam int CFG_DATA_W = 13;

    localparam logic [12:0] LINE_WIDTH_RST   = 13'd640;
    localparam logic        FILL_OUTSIDE_RST = 1'b1;
    localparam logic        COUNT_MODE_RST   = 1'b0;

    // result queue between the column store and the output port
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic [31:0] sum;
        logic        written;
        logic        line_end;
    } t_out_word;

endpackage

FILE: rtl/mii_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mii_out_fifo
// Small result queue; absorbs words in flight while the output stalls.
// ----------------------------------------------------------------------------
module mii_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mii_pkg::t_out_word    i_word,
    input  logic                  i_pop,
    output mii_pkg::t_out_word    o_word,
    output logic [1:0]            o_count
);
    import mii_pkg::*;

    localparam logic [1:0] LAST_SLOT = 2'(OUT_DEPTH - 1);

    t_out_word  r_slot [OUT_DEPTH];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? 2'd0 : r_wr_ptr + 2'd1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? 2'd0 : r_rd_ptr + 2'd1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

    assign o_word  = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: rtl/masked_integral_image_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_integral_image_top
// Masked summed-area table over a raster pixel stream, one result per pixel.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless stalled; returns one result word per
// pixel, in order, through the read stage and result queue. The rate is set
// by the column store: each pixel does one read-modify-write of its column
// entry, read in the accept cycle and written back the next, with a forward
// path when consecutive pixels hit the same column (line width of one). A
// three-word result queue keeps input flowing while the output stalls.
// Column entries are not cleared after reset; the first row of each frame
// writes every column before any later row reads it.
module masked_integral_image_top #(
    parameter int MAX_WIDTH = mii_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_pixel,
    input  logic                          i_inside_req,
    input  logic                          i_frame_start,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_sum,
    output logic                          o_written,
    output logic                          o_line_end,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [mii_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mii_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration
    logic [12:0] r_line_width;
    logic        r_fill_outside;
    logic        r_count_mode;

    // row state
    logic [CW-1:0] r_col, n_col;
    logic [31:0]   r_row_sum, n_row_sum;
    logic          r_first, n_first;

    // read stage
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    logic [31:0]   r_s1_row;
    logic          r_s1_inside;
    logic          r_s1_first;
    logic          r_s1_written;
    logic          r_s1_last;
    logic          r_fwd;
    logic [31:0]   r_fwd_data;

    logic [31:0]   r_col_mem [MAX_WIDTH];
    logic [31:0]   r_mem_q;

    logic          in_acc;
    logic [CW-1:0] col_cur;
    logic [31:0]   row_base, row_new, row_inc;
    logic          first_cur;
    logic [12:0]   lw_m1;
    logic          last;
    logic          s1_we;
    logic [31:0]   above, result;
    logic          out_pop;
    logic [1:0]    q_count;
    t_out_word     s1_word, q_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_fill_outside <= FILL_OUTSIDE_RST;
            r_count_mode   <= COUNT_MODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[12:0];
                CFG_FILL_OUTSIDE: r_fill_outside <= i_cfg_data[0];
                CFG_COUNT_MODE:   r_count_mode   <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (32'(r_s1_valid) + 32'(q_count)) >= OUT_DEPTH;

    // accept-cycle work: row sum, column step, store read
    always_comb begin
        col_cur   = i_frame_start ? '0 : r_col;
        row_base  = i_frame_start ? '0 : r_row_sum;
        first_cur = i_frame_start ? 1'b1 : r_first;
        lw_m1     = (r_line_width == '0) ? '0 : r_line_width - 13'd1;
        last      = (32'(col_cur) >= 32'(lw_m1)) || (32'(col_cur) >= MAX_WIDTH - 1);
        row_inc   = r_count_mode ? 32'd1 : {16'd0, i_pixel};
        row_new   = i_inside_req ? row_base + row_inc : row_base;
        if (last) begin
            n_col     = '0;
            n_row_sum = '0;
            n_first   = 1'b0;
        end else begin
            n_col     = CW'(col_cur + 1'b1);
            n_row_sum = row_new;
            n_first   = first_cur;
        end
    end

    // write-back stage; outside pixels on the first row store zero
    assign s1_we  = r_s1_valid && (r_s1_inside || r_s1_first);
    assign above  = r_s1_first ? '0 : (r_fwd ? r_fwd_data : r_mem_q);
    assign result = r_s1_inside ? r_s1_row + above : above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row_sum  <= '0;
            r_first    <= 1'b1;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                r_col     <= n_col;
                r_row_sum <= n_row_sum;
                r_first   <= n_first;
                // store write of the previous word lands this cycle
                r_fwd     <= s1_we && (r_s1_col == col_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col     <= col_cur;
            r_s1_row     <= row_new;
            r_s1_inside  <= i_inside_req;
            r_s1_first   <= first_cur;
            r_s1_written <= i_inside_req || r_fill_outside;
            r_s1_last    <= last;
            r_fwd_data   <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= r_col_mem[col_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_we) begin
            r_col_mem[r_s1_col] <= result;
        end
    end

    assign s1_word.sum      = result;
    assign s1_word.written  = r_s1_written;
    assign s1_word.line_end = r_s1_last;

    assign out_pop = o_out_valid && !i_out_stall;

    mii_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_word  (s1_word),
        .i_pop   (out_pop),
        .o_word  (q_word),
        .o_count (q_count)
    );

    assign o_out_valid = (q_count != 2'd0);
    assign o_sum       = q_word.sum;
    assign o_written   = q_word.written;
    assign o_line_end  = q_word.line_end;

    // the queue always has room for the word leaving the read stage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (32'(q_count) < OUT_DEPTH))
        else $error("result queue overflow");

    // every accepted pixel reaches the write-back stage next cycle
    a_accept_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted pixel lost before write-back");

    // forwarding only follows a store write in the cycle before
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> $past(s1_we))
        else $error("forward without a preceding store write");

    // column counter stays inside the store
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < MAX_WIDTH)
        else $error("column index out of range");

endmodule
